>>> rtl/lhr_pkg.sv
// ----------------------------------------------------------------------------
// lhr_pkg: shared types and constants
// Widths of the fixed fields and the lane result record.
// ----------------------------------------------------------------------------
package lhr_pkg;

  localparam int unsigned MAX_LANES = 16;
  localparam int unsigned PAIRS     = 8;
  localparam int unsigned IDX_W     = 14;
  localparam int unsigned WGT_W     = 16;
  localparam int unsigned CFG_W     = 15;
  localparam int unsigned TOT_W     = 30;
  localparam int unsigned LIM_W     = 17;

  localparam logic [30:0] TINY_LIMIT = 31'h2F80_0000;
  localparam logic [7:0]  EXP_RAISE  = 8'd32;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  typedef struct packed {
    logic [31:0] value;
    logic        tiny;
  } lane_res_t;

endpackage

>>> rtl/lhr_if.sv
// ----------------------------------------------------------------------------
// lhr_in_if / lhr_out_if: stream channels
// Valid/ready channels; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface lhr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [13:0] weight_index;
  logic [15:0] weight_value;
  logic [63:0] lane_pair_0;
  logic [63:0] lane_pair_1;
  logic [63:0] lane_pair_2;
  logic [63:0] lane_pair_3;
  logic [63:0] lane_pair_4;
  logic [63:0] lane_pair_5;
  logic [63:0] lane_pair_6;
  logic [63:0] lane_pair_7;

  modport source (output valid, command, weight_index, weight_value,
                  lane_pair_0, lane_pair_1, lane_pair_2, lane_pair_3,
                  lane_pair_4, lane_pair_5, lane_pair_6, lane_pair_7,
                  input ready);
  modport sink (input valid, command, weight_index, weight_value,
                lane_pair_0, lane_pair_1, lane_pair_2, lane_pair_3,
                lane_pair_4, lane_pair_5, lane_pair_6, lane_pair_7,
                output ready);
endinterface

interface lhr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_pair_0;
  logic [63:0] out_pair_1;
  logic [63:0] out_pair_2;
  logic [63:0] out_pair_3;
  logic [63:0] out_pair_4;
  logic [63:0] out_pair_5;
  logic [63:0] out_pair_6;
  logic [63:0] out_pair_7;
  logic        was_scaled;
  logic [29:0] scale_total;
  logic        last_site;

  modport source (output valid, out_pair_0, out_pair_1, out_pair_2, out_pair_3,
                  out_pair_4, out_pair_5, out_pair_6, out_pair_7,
                  was_scaled, scale_total, last_site, input ready);
  modport sink (input valid, out_pair_0, out_pair_1, out_pair_2, out_pair_3,
                out_pair_4, out_pair_5, out_pair_6, out_pair_7,
                was_scaled, scale_total, last_site, output ready);
endinterface

>>> rtl/lhr_lane.sv
// ----------------------------------------------------------------------------
// lhr_lane: one likelihood lane
// Tests a binary32 value for magnitude below 2^-32 and forms its value
// times 2^32, normalizing subnormals.
// ----------------------------------------------------------------------------
module lhr_lane (
  input  logic [31:0]        lane_in,
  output lhr_pkg::lane_res_t res
);

  logic [30:0] mag;
  logic [4:0]  msb;
  logic [22:0] frac;
  logic [7:0]  sub_exp;
  logic [45:0] shifted;

  assign mag = lane_in[30:0];

  always_comb begin
    msb = '0;
    for (int i = 0; i < 23; i++) begin
      if (mag[i]) msb = 5'(i);
    end
  end

  assign shifted = {23'd0, mag[22:0]} << (5'd23 - msb);
  assign frac    = shifted[22:0];
  assign sub_exp = 8'(msb) + 8'd10;

  always_comb begin
    res.tiny = (mag < lhr_pkg::TINY_LIMIT);
    if (mag == '0) begin
      res.value = lane_in;
    end else if (mag[30:23] != '0) begin
      res.value = {lane_in[31], mag[30:23] + lhr_pkg::EXP_RAISE, mag[22:0]};
    end else begin
      res.value = {lane_in[31], sub_exp, frac};
    end
  end

endmodule

>>> rtl/lhr_weight_ram.sv
// ----------------------------------------------------------------------------
// lhr_weight_ram: site weight table
// One write port and one registered read port with read enable.
// ----------------------------------------------------------------------------
module lhr_weight_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [lhr_pkg::WGT_W-1:0]  wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [lhr_pkg::WGT_W-1:0]  rdata
);

  logic [lhr_pkg::WGT_W-1:0] mem [DEPTH];
  logic [lhr_pkg::WGT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/likelihood_underflow_rescaler.sv
// ----------------------------------------------------------------------------
// likelihood_underflow_rescaler: per-site likelihood rescaling
// Sixteen lanes test and scale a site in parallel; a merge stage decides
// and accumulates the site weight into the pass total.
// ----------------------------------------------------------------------------
// One item per cycle unless the output stalls; a beat is registered in the
// lane stage, then the output register. Weight load beats produce no result.
// Rate is set by the lane stage and the registered weight table read feeding
// the accumulator. The table is undefined until loaded; it is not cleared.
module likelihood_underflow_rescaler #(
  parameter int unsigned WEIGHT_DEPTH = 16384,
  parameter int unsigned LANES        = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lhr_in_if.sink                    in_bus,
  lhr_out_if.source                 out_bus,
  input  logic                      cfg_we,
  input  logic [lhr_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(WEIGHT_DEPTH);
  localparam int unsigned CW = (AW < 14) ? AW : 14;
  localparam logic [lhr_pkg::LIM_W-1:0] DEPTH_L = lhr_pkg::LIM_W'(WEIGHT_DEPTH);

  logic [lhr_pkg::CFG_W-1:0] site_count_r;
  logic [CW-1:0]             cnt_r;
  logic [lhr_pkg::TOT_W-1:0] acc_r;

  logic [lhr_pkg::LIM_W-1:0] limit;
  logic [lhr_pkg::LIM_W-1:0] cnt_inc;
  logic                      last_now;
  logic                      in_acc, is_proc;

  logic [31:0]        lane_in  [lhr_pkg::MAX_LANES];
  lhr_pkg::lane_res_t lane_res [lhr_pkg::MAX_LANES];
  logic [31:0]        lane_sel [lhr_pkg::MAX_LANES];
  logic               all_small;

  logic                      s1_v_r, s1_small_r, s1_last_r;
  logic [31:0]               s1_lane_r [lhr_pkg::MAX_LANES];
  logic [lhr_pkg::WGT_W-1:0] wgt;
  logic                      s1_adv;

  logic                      out_v_r, out_small_r, out_last_r;
  logic [31:0]               out_lane_r [lhr_pkg::MAX_LANES];
  logic [lhr_pkg::TOT_W-1:0] out_tot_r, sum;

  logic [63:0] pair_in [lhr_pkg::PAIRS];

  assign pair_in[0] = in_bus.lane_pair_0;
  assign pair_in[1] = in_bus.lane_pair_1;
  assign pair_in[2] = in_bus.lane_pair_2;
  assign pair_in[3] = in_bus.lane_pair_3;
  assign pair_in[4] = in_bus.lane_pair_4;
  assign pair_in[5] = in_bus.lane_pair_5;
  assign pair_in[6] = in_bus.lane_pair_6;
  assign pair_in[7] = in_bus.lane_pair_7;

  genvar g;
  generate
    for (g = 0; g < lhr_pkg::MAX_LANES; g++) begin : g_lane
      assign lane_in[g] = pair_in[g/2][32*(g%2) +: 32];
      if (g < LANES) begin : g_core
        lhr_lane u_lane (.lane_in(lane_in[g]), .res(lane_res[g]));
      end else begin : g_pass
        assign lane_res[g] = '{value: lane_in[g], tiny: 1'b1};
      end
      assign lane_sel[g] = all_small ? lane_res[g].value : lane_in[g];
    end
  endgenerate

  always_comb begin
    all_small = 1'b1;
    for (int i = 0; i < lhr_pkg::MAX_LANES; i++) begin
      all_small = all_small & lane_res[i].tiny;
    end
  end

  always_comb begin
    limit = lhr_pkg::LIM_W'(site_count_r);
    if (limit == '0) limit = lhr_pkg::LIM_W'(1);
    if (limit > DEPTH_L) limit = DEPTH_L;
  end

  assign cnt_inc  = lhr_pkg::LIM_W'(cnt_r) + lhr_pkg::LIM_W'(1);
  assign last_now = (cnt_inc >= limit);

  assign s1_adv       = !out_v_r || out_bus.ready;
  assign in_bus.ready = !s1_v_r || s1_adv;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign is_proc      = (in_bus.command == lhr_pkg::CMD_PROCESS);

  lhr_weight_ram #(.DEPTH(WEIGHT_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (in_acc && !is_proc),
    .waddr (AW'(in_bus.weight_index)),
    .wdata (in_bus.weight_value),
    .re    (in_acc && is_proc),
    .raddr (AW'(cnt_r)),
    .rdata (wgt)
  );

  assign sum = acc_r + (s1_small_r ? lhr_pkg::TOT_W'(wgt) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_count_r <= lhr_pkg::CFG_W'(1);
      cnt_r        <= '0;
      acc_r        <= '0;
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_we) site_count_r <= cfg_wdata;
      if (in_acc && is_proc) begin
        cnt_r <= last_now ? '0 : cnt_inc[CW-1:0];
      end
      if (in_bus.ready) s1_v_r <= in_acc && is_proc;
      if (s1_adv) begin
        out_v_r <= s1_v_r;
        if (s1_v_r) acc_r <= s1_last_r ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_proc) begin
      s1_small_r <= all_small;
      s1_last_r  <= last_now;
      for (int i = 0; i < lhr_pkg::MAX_LANES; i++) s1_lane_r[i] <= lane_sel[i];
    end
    if (s1_adv && s1_v_r) begin
      out_small_r <= s1_small_r;
      out_last_r  <= s1_last_r;
      out_tot_r   <= sum;
      for (int i = 0; i < lhr_pkg::MAX_LANES; i++) out_lane_r[i] <= s1_lane_r[i];
    end
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.out_pair_0  = {out_lane_r[1],  out_lane_r[0]};
  assign out_bus.out_pair_1  = {out_lane_r[3],  out_lane_r[2]};
  assign out_bus.out_pair_2  = {out_lane_r[5],  out_lane_r[4]};
  assign out_bus.out_pair_3  = {out_lane_r[7],  out_lane_r[6]};
  assign out_bus.out_pair_4  = {out_lane_r[9],  out_lane_r[8]};
  assign out_bus.out_pair_5  = {out_lane_r[11], out_lane_r[10]};
  assign out_bus.out_pair_6  = {out_lane_r[13], out_lane_r[12]};
  assign out_bus.out_pair_7  = {out_lane_r[15], out_lane_r[14]};
  assign out_bus.was_scaled  = out_small_r;
  assign out_bus.scale_total = out_tot_r;
  assign out_bus.last_site   = out_last_r;

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !s1_v_r && !out_v_r)
    else $error("pipeline not empty after reset");
  a_cnt_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_proc && last_now) |=> cnt_r == '0)
    else $error("site counter did not wrap on last site");
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_v_r && s1_last_r) |=> acc_r == '0)
    else $error("total not cleared after last site");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    lhr_pkg::LIM_W'(cnt_r) < DEPTH_L)
    else $error("site counter beyond table depth");
`endif

endmodule
